[sv/bcpe_pkg.sv]
// ----------------------------------------------------------------------------
// Bezier curve point evaluator package
// Shared controller states and the command and status groups that pass
// between the controller and the datapath.
// ----------------------------------------------------------------------------
package bcpe_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_COEF,
    ST_PASS1,
    ST_GAP,
    ST_PASS2,
    ST_DRAIN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic coef_init;
    logic coef_step;
    logic eval_start;
    logic load_we;
    logic rd_en;
    logic pass2;
    logic first;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } sts_t;

  localparam int IN_FIELD_W = 4;

endpackage

[sv/bcpe_ram.sv]
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
module bcpe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[sv/bcpe_ctrl.sv]
// ----------------------------------------------------------------------------
// Bezier evaluator controller
// Holds the point count, sequences the coefficient build, the load writes
// and the two evaluation passes over the stored points.
// ----------------------------------------------------------------------------
module bcpe_ctrl #(
  parameter int MAX_POINTS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [4:0]                    cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          func,
  input  logic [3:0]                    point_index,
  output bcpe_pkg::cmd_t                cmd,
  output logic [$clog2(MAX_POINTS)-1:0] rd_addr,
  output logic [$clog2(MAX_POINTS)-1:0] ld_addr,
  input  bcpe_pkg::sts_t                sts
);

  import bcpe_pkg::*;

  localparam int IW   = $clog2(MAX_POINTS);
  localparam int CW   = $clog2(MAX_POINTS + 1);
  localparam int CFW  = CW > 5 ? CW : 5;
  localparam int CMPW = CW > IN_FIELD_W ? CW : IN_FIELD_W;

  state_t        state, state_next;
  logic [CW-1:0] count;
  logic [CW-1:0] k;
  logic [IW-1:0] idx;
  logic [IW-1:0] last;
  logic [CFW-1:0] cfg_ext;
  logic [CMPW-1:0] pi_ext;
  logic          accept;

  assign last     = IW'(count - CW'(1));
  assign cfg_ext  = CFW'(cfg_wdata);
  assign pi_ext   = CMPW'(point_index);
  assign ld_addr  = pi_ext[IW-1:0];
  assign rd_addr  = idx;
  assign in_ready = (state == ST_IDLE) && !cfg_we && !rst;
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (cfg_we) begin
          state_next = ST_COEF;
        end else if (accept && func) begin
          state_next = (count == '0) ? ST_DONE : ST_PASS1;
        end
      end
      ST_COEF: begin
        if (k >= count) begin
          state_next = ST_IDLE;
        end
      end
      ST_PASS1: begin
        if (idx == last) begin
          state_next = ST_GAP;
        end
      end
      ST_GAP:   state_next = ST_PASS2;
      ST_PASS2: begin
        if (idx == '0) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: state_next = ST_DONE;
      ST_DONE: begin
        if (sts.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    case (state)
      ST_IDLE: begin
        cmd.coef_init  = cfg_we;
        cmd.eval_start = accept && func;
        cmd.load_we    = accept && !func && (pi_ext < CMPW'(count));
      end
      ST_COEF: begin
        cmd.coef_step = (k < count);
      end
      ST_PASS1: begin
        cmd.rd_en = 1'b1;
        cmd.first = (idx == '0);
      end
      ST_PASS2: begin
        cmd.rd_en = 1'b1;
        cmd.pass2 = 1'b1;
        cmd.first = (idx == last);
      end
      ST_DONE: begin
        cmd.out_load = sts.out_free;
      end
      default: cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
      k     <= '0;
      idx   <= '0;
    end else begin
      state <= state_next;
      if (state == ST_IDLE && cfg_we) begin
        count <= (cfg_ext > CFW'(MAX_POINTS)) ? CW'(MAX_POINTS) : cfg_ext[CW-1:0];
        k     <= CW'(1);
      end else if (state == ST_COEF && k < count) begin
        k <= k + CW'(1);
      end
      case (state)
        ST_IDLE:  idx <= '0;
        ST_PASS1: idx <= (idx == last) ? idx : idx + IW'(1);
        ST_GAP:   idx <= last;
        ST_PASS2: idx <= (idx == '0) ? idx : idx - IW'(1);
        default:  idx <= idx;
      endcase
    end
  end

endmodule

[sv/bcpe_datapath.sv]
// ----------------------------------------------------------------------------
// Bezier evaluator datapath
// Binomial coefficient row, scaled point memory, partial product memory,
// the shared power multiplier, the accumulators and the result register.
// ----------------------------------------------------------------------------
module bcpe_datapath #(
  parameter int MAX_POINTS  = 16,
  parameter int T_FRAC_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  bcpe_pkg::cmd_t                cmd,
  output bcpe_pkg::sts_t                sts,
  input  logic [$clog2(MAX_POINTS)-1:0] rd_addr,
  input  logic [$clog2(MAX_POINTS)-1:0] ld_addr,
  input  logic signed [31:0]            x_coord,
  input  logic signed [31:0]            y_coord,
  input  logic signed [31:0]            z_coord,
  input  logic [16:0]                   t_param,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [31:0]            x_out,
  output logic signed [31:0]            y_out,
  output logic signed [31:0]            z_out
);

  import bcpe_pkg::*;

  localparam int IW    = $clog2(MAX_POINTS);
  localparam int COEFW = MAX_POINTS - 1;
  localparam int SPW   = COEFW + 32;
  localparam int UW    = T_FRAC_BITS + 1;
  localparam int TCW   = UW > 17 ? UW : 17;
  localparam int ACCW  = SPW + IW + 1;
  localparam int PRW   = SPW + UW + 1;

  localparam logic signed [ACCW-1:0] SAT_HI = ACCW'(32'sh7fffffff);
  localparam logic signed [ACCW-1:0] SAT_LO = -ACCW'(32'sh7fffffff) - ACCW'(1);

  logic [COEFW-1:0] coef [MAX_POINTS];
  logic [COEFW-1:0] coef_sel;

  logic [2:0][SPW-1:0] sp_wdata;
  logic [2:0][SPW-1:0] sp_q;
  logic [2:0][SPW-1:0] r_q;
  logic [2:0][SPW-1:0] val;
  logic signed [31:0]  coord [3];
  logic signed [PRW-1:0] prod [3];
  logic signed [ACCW-1:0] acc [3];
  logic signed [ACCW-1:0] sat [3];
  logic signed [SPW-1:0]  a_sel;

  logic [UW-1:0]   t_reg, omt_reg, pw, base;
  logic [2*UW-1:0] pw_prod;
  logic [TCW-1:0]  t_ext, t_clamp;

  logic          v1, pass2_d, first_d;
  logic [IW-1:0] addr_d;

  assign coef_sel = coef[ld_addr];
  assign coord[0] = x_coord;
  assign coord[1] = y_coord;
  assign coord[2] = z_coord;

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      sp_wdata[l] = SPW'($signed({1'b0, coef_sel}) * coord[l]);
    end
  end

  bcpe_ram #(.WIDTH(3 * SPW), .DEPTH(MAX_POINTS)) u_sp_ram (
    .clk   (clk),
    .we    (cmd.load_we),
    .waddr (ld_addr),
    .wdata (sp_wdata),
    .raddr (rd_addr),
    .rdata (sp_q)
  );

  bcpe_ram #(.WIDTH(3 * SPW), .DEPTH(MAX_POINTS)) u_r_ram (
    .clk   (clk),
    .we    (v1 && !pass2_d),
    .waddr (addr_d),
    .wdata (val),
    .raddr (rd_addr),
    .rdata (r_q)
  );

  assign base    = pass2_d ? omt_reg : t_reg;
  assign pw_prod = pw * base;
  assign t_ext   = TCW'(t_param);
  assign t_clamp = (t_ext > (TCW'(1) << T_FRAC_BITS)) ? (TCW'(1) << T_FRAC_BITS) : t_ext;

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      a_sel   = pass2_d ? $signed(r_q[l]) : $signed(sp_q[l]);
      prod[l] = a_sel * $signed({1'b0, pw});
      val[l]  = first_d ? a_sel : SPW'(prod[l] >>> T_FRAC_BITS);
      if (acc[l] > SAT_HI) begin
        sat[l] = SAT_HI;
      end else if (acc[l] < SAT_LO) begin
        sat[l] = SAT_LO;
      end else begin
        sat[l] = acc[l];
      end
    end
  end

  assign sts.out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (cmd.coef_init) begin
      coef[0] <= COEFW'(1);
      for (int j = 1; j < MAX_POINTS; j++) begin
        coef[j] <= '0;
      end
    end else if (cmd.coef_step) begin
      for (int j = 1; j < MAX_POINTS; j++) begin
        coef[j] <= coef[j] + coef[j-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    pass2_d <= cmd.pass2;
    first_d <= cmd.first;
    addr_d  <= rd_addr;
    if (cmd.eval_start) begin
      t_reg   <= t_clamp[UW-1:0];
      omt_reg <= UW'((TCW'(1) << T_FRAC_BITS) - t_clamp);
    end
    if (v1) begin
      pw <= first_d ? base : UW'(pw_prod >> T_FRAC_BITS);
    end
    for (int l = 0; l < 3; l++) begin
      if (cmd.eval_start) begin
        acc[l] <= '0;
      end else if (v1 && pass2_d) begin
        acc[l] <= acc[l] + ACCW'($signed(val[l]));
      end
    end
    if (cmd.out_load) begin
      x_out <= sat[0][31:0];
      y_out <= sat[1][31:0];
      z_out <= sat[2][31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v1 <= cmd.rd_en;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

[sv/bezier_curve_point_evaluator.sv]
// ----------------------------------------------------------------------------
// Bezier curve point evaluator
// Evaluates a 3-D Bezier curve in Bernstein form in fixed point.
// ----------------------------------------------------------------------------
// A write of point_count (capped at MAX_POINTS) rebuilds the binomial row, one
// Pascal row step per cycle; no beat is taken in the cycle of the write nor
// while the row is being built.
// A load beat (tuser 0) whose index is below the count stores its point
// pre-scaled by the coefficient in the cycle it is accepted, so loads stream at
// one per cycle while no count write or evaluation holds s_tready low. An
// evaluate beat (tuser 1) walks the point memory twice, once per cycle for each
// point; the next beat is taken once the result sits in the output register.
// Loading a point below the count before evaluating is required.
// ----------------------------------------------------------------------------
module bezier_curve_point_evaluator #(
  parameter int MAX_POINTS  = 16,
  parameter int T_FRAC_BITS = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic [4:0]   cfg_wdata,
  input  logic         s_tvalid,
  output logic         s_tready,
  // point_index[3:0], x_coord[35:4], y_coord[67:36], z_coord[99:68],
  // t_param[116:100], zero fill
  input  logic [119:0] s_tdata,
  // func
  input  logic         s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // x_out[31:0], y_out[63:32], z_out[95:64]
  output logic [95:0]  m_tdata
);

  import bcpe_pkg::*;

  localparam int IW = $clog2(MAX_POINTS);

  cmd_t          cmd;
  sts_t          sts;
  logic [IW-1:0] rd_addr;
  logic [IW-1:0] ld_addr;
  logic signed [31:0] x_out, y_out, z_out;

  bcpe_ctrl #(.MAX_POINTS(MAX_POINTS)) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .in_valid    (s_tvalid),
    .in_ready    (s_tready),
    .func        (s_tuser),
    .point_index (s_tdata[3:0]),
    .cmd         (cmd),
    .rd_addr     (rd_addr),
    .ld_addr     (ld_addr),
    .sts         (sts)
  );

  bcpe_datapath #(
    .MAX_POINTS  (MAX_POINTS),
    .T_FRAC_BITS (T_FRAC_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .rd_addr   (rd_addr),
    .ld_addr   (ld_addr),
    .x_coord   (s_tdata[35:4]),
    .y_coord   (s_tdata[67:36]),
    .z_coord   (s_tdata[99:68]),
    .t_param   (s_tdata[116:100]),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .x_out     (x_out),
    .y_out     (y_out),
    .z_out     (z_out)
  );

  assign m_tdata = {z_out, y_out, x_out};

endmodule

[bench/tb.sv]
// ----------------------------------------------------------------------------
// Bezier curve point evaluator testbench
// Drives load and evaluate beats with random gaps and output stalls. A local
// model of the curve predicts the results, apart from directed beats that carry
// a fixed expected value, and each output beat is checked field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb;

  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_EVAL = 1'b1;
  localparam int   NPTS      = 16;
  localparam int   ONE       = 1 << 16;
  localparam int   SETTLE    = 2 * NPTS + 12;
  localparam int   LIMIT     = 600000;

  typedef struct {
    bit          is_cfg;
    logic [4:0]  cfg_val;
    logic        func;
    logic [3:0]  idx;
    logic [31:0] x, y, z;
    logic [16:0] t;
    bit          typed;
    logic [95:0] res;
  } step_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         cfg_we = 1'b0;
  logic [4:0]   cfg_wdata = '0;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [119:0] s_tdata = '0;
  logic         s_tuser = 1'b0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [95:0]  m_tdata;

  int           cycles = 0;
  int           errors = 0;
  bit           busy_mode = 1'b1;
  logic [95:0]  pending_points[$];
  step_t        steps[$];

  int           count_cur;
  int           binom[NPTS];
  longint       sx_pts[NPTS], sy_pts[NPTS], sz_pts[NPTS];

  bezier_curve_point_evaluator u_dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("[bezier_curve_point_evaluator] ERROR");
      $finish;
    end
  end

  function automatic void set_count(int v);
    count_cur = (v > NPTS) ? NPTS : v;
    binom[0] = 1;
    for (int i = 1; i < count_cur; i++) begin
      binom[i] = binom[i - 1] * (count_cur - i) / i;
    end
  endfunction

  function automatic void store_point(logic [3:0] idx, logic [31:0] x, logic [31:0] y,
                                      logic [31:0] z);
    if (idx < count_cur) begin
      sx_pts[idx] = longint'(binom[idx]) * longint'(signed'(x));
      sy_pts[idx] = longint'(binom[idx]) * longint'(signed'(y));
      sz_pts[idx] = longint'(binom[idx]) * longint'(signed'(z));
    end
  endfunction

  function automatic longint frac_mul(longint a, longint u);
    return (a * u) >>> 16;
  endfunction

  function automatic logic [31:0] clamp32(longint v);
    if (v > 64'sd2147483647) v = 64'sd2147483647;
    if (v < -64'sd2147483648) v = -64'sd2147483648;
    return v[31:0];
  endfunction

  function automatic logic [95:0] curve_point(logic [16:0] tp);
    longint rx[NPTS], ry[NPTS], rz[NPTS];
    longint ax, ay, az, tt, omt, pw;
    int     last;
    if (count_cur == 0) return '0;
    tt   = (tp > ONE) ? ONE : tp;
    omt  = ONE - tt;
    last = count_cur - 1;
    rx[0] = sx_pts[0];
    ry[0] = sy_pts[0];
    rz[0] = sz_pts[0];
    pw = tt;
    for (int i = 1; i <= last; i++) begin
      rx[i] = frac_mul(sx_pts[i], pw);
      ry[i] = frac_mul(sy_pts[i], pw);
      rz[i] = frac_mul(sz_pts[i], pw);
      pw = (pw * tt) >> 16;
    end
    ax = rx[last];
    ay = ry[last];
    az = rz[last];
    pw = omt;
    for (int i = last; i > 0; i--) begin
      ax += frac_mul(rx[i - 1], pw);
      ay += frac_mul(ry[i - 1], pw);
      az += frac_mul(rz[i - 1], pw);
      pw = (pw * omt) >> 16;
    end
    return {clamp32(az), clamp32(ay), clamp32(ax)};
  endfunction

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (busy_mode || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 7))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return 32'hffff_ffff;
      3: return 32'h0000_0000;
      4: return $urandom_range(0, 65535) - 32768;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [16:0] rand_t();
    case ($urandom_range(0, 9))
      0: return 17'd0;
      1: return 17'd65536;
      2: return 17'($urandom_range(65537, 131071));
      default: return 17'($urandom_range(0, 65536));
    endcase
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h expected %h at cycle %0d", what, got, want, cycles);
    errors++;
  endtask

  always @(posedge clk) begin
    logic [95:0] want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_points.size() == 0) begin
        report("unexpected beat", m_tdata[31:0], 32'h0);
      end else begin
        want = pending_points.pop_front();
        if (m_tdata[31:0] !== want[31:0]) report("x_out", m_tdata[31:0], want[31:0]);
        if (m_tdata[63:32] !== want[63:32]) report("y_out", m_tdata[63:32], want[63:32]);
        if (m_tdata[95:64] !== want[95:64]) report("z_out", m_tdata[95:64], want[95:64]);
      end
    end
  end

  initial begin
    int stall;
    stall = 0;
    forever begin
      @(posedge clk);
      if (stall > 0) begin
        m_tready <= 1'b0;
        stall--;
      end else if (busy_mode || $urandom_range(0, 99) < 70) begin
        m_tready <= 1'b1;
      end else begin
        m_tready <= 1'b0;
        stall = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30) : $urandom_range(0, 2);
      end
    end
  end

  task automatic write_count(logic [4:0] v);
    s_tvalid <= 1'b0;
    while (pending_points.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    set_count(v);
  endtask

  task automatic send_beat(logic func, logic [3:0] idx, logic [31:0] x, logic [31:0] y,
                           logic [31:0] z, logic [16:0] tp, bit typed, logic [95:0] res);
    int gap;
    gap = gap_len();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= func;
    s_tdata  <= {3'b000, tp, z, y, x, idx};
    do @(posedge clk); while (!s_tready);
    if (func == FUNC_LOAD) begin
      store_point(idx, x, y, z);
    end else begin
      pending_points.push_back(typed ? res : curve_point(tp));
    end
  endtask

  task automatic add_cfg(logic [4:0] v);
    step_t s;
    s = '{default: '0};
    s.is_cfg  = 1'b1;
    s.cfg_val = v;
    steps.push_back(s);
  endtask

  task automatic add_beat(logic func, logic [3:0] idx, logic [31:0] x, logic [31:0] y,
                          logic [31:0] z, logic [16:0] tp, bit typed, logic [95:0] res);
    step_t s;
    s = '{default: '0};
    s.func = func;
    s.idx = idx;
    s.x = x;
    s.y = y;
    s.z = z;
    s.t = tp;
    s.typed = typed;
    s.res = res;
    steps.push_back(s);
  endtask

  initial begin
    int count_list[8];
    int n, lim;
    count_list = '{31, 0, 1, 2, 16, 5, 0, 31};
    set_count(0);
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    add_beat(FUNC_EVAL, 4'd0, 0, 0, 0, 17'd32768, 1, '0);
    add_beat(FUNC_LOAD, 4'd0, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 17'd0, 0, '0);
    add_beat(FUNC_EVAL, 4'd15, 0, 0, 0, 17'h1ffff, 1, '0);
    add_cfg(5'd1);
    add_beat(FUNC_LOAD, 4'd0, 32'h7fff_ffff, 32'h8000_0000, 32'h0000_0001, 17'h1ffff, 0, '0);
    add_beat(FUNC_EVAL, 4'd0, 0, 0, 0, 17'h1ffff, 1,
             {32'h0000_0001, 32'h8000_0000, 32'h7fff_ffff});
    add_beat(FUNC_LOAD, 4'd15, 32'h1234_5678, 0, 0, 17'd0, 0, '0);
    add_beat(FUNC_EVAL, 4'd15, 0, 0, 0, 17'd0, 1,
             {32'h0000_0001, 32'h8000_0000, 32'h7fff_ffff});
    add_cfg(5'd2);
    add_beat(FUNC_LOAD, 4'd0, 32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff, 17'd0, 0, '0);
    add_beat(FUNC_LOAD, 4'd1, 32'h7fff_ffff, 32'h8000_0000, 32'h0001_0000, 17'd0, 0, '0);
    add_beat(FUNC_EVAL, 4'd0, 0, 0, 0, 17'd0, 0, '0);
    add_beat(FUNC_EVAL, 4'd0, 0, 0, 0, 17'd65536, 0, '0);
    add_beat(FUNC_EVAL, 4'd0, 0, 0, 0, 17'd32768, 0, '0);
    add_beat(FUNC_EVAL, 4'd0, 0, 0, 0, 17'h1ffff, 0, '0);
    add_beat(FUNC_EVAL, 4'd0, 0, 0, 0, 17'd1, 0, '0);
    add_cfg(5'd3);
    add_beat(FUNC_LOAD, 4'd2, 32'hffff_ffff, 32'h0000_0000, 32'h8000_0000, 17'd0, 0, '0);
    add_beat(FUNC_LOAD, 4'd1, 32'h0000_0000, 32'hffff_ffff, 32'h7fff_ffff, 17'd0, 0, '0);
    add_beat(FUNC_EVAL, 4'd0, 0, 0, 0, 17'd40000, 0, '0);
    add_beat(FUNC_EVAL, 4'd9, 0, 0, 0, 17'd20000, 0, '0);

    // Reading index 2 while still unwritten is avoided: it is loaded above first.
    foreach (steps[i]) begin
      if (steps[i].is_cfg) write_count(steps[i].cfg_val);
      else send_beat(steps[i].func, steps[i].idx, steps[i].x, steps[i].y, steps[i].z,
                     steps[i].t, steps[i].typed, steps[i].res);
    end

    foreach (count_list[p]) begin
      busy_mode = (p % 3 == 2);
      write_count(5'(count_list[p] == 5 ? $urandom_range(0, 31) : count_list[p]));
      for (int i = 0; i < count_cur; i++) begin
        send_beat(FUNC_LOAD, 4'(i), rand_coord(), rand_coord(), rand_coord(), rand_t(), 0,
                  '0);
      end
      n = 0;
      while (n < 85) begin
        lim = $urandom_range(0, 99);
        if (lim < 10) begin
          if (count_cur < NPTS) begin
            send_beat(FUNC_LOAD, 4'($urandom_range(count_cur, NPTS - 1)), $urandom,
                      $urandom, $urandom, rand_t(), 0, '0);
          end
        end else if (lim < 45 && count_cur > 0) begin
          send_beat(FUNC_LOAD, 4'($urandom_range(0, count_cur - 1)), rand_coord(),
                    rand_coord(), rand_coord(), rand_t(), 0, '0);
          n++;
        end else begin
          send_beat(FUNC_EVAL, 4'($urandom_range(0, 15)), $urandom, $urandom, $urandom,
                    rand_t(), 0, '0);
          n++;
        end
      end
    end

    s_tvalid <= 1'b0;
    while (pending_points.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (errors == 0) begin
      $display("[bezier_curve_point_evaluator] OK");
    end else begin
      $display("[bezier_curve_point_evaluator] ERROR");
    end
    $finish;
  end

endmodule
